// ===== hw/rtl/twv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twv_pkg
// Shared constants, state encoding and control struct of the trapped water
// volume core.
// ----------------------------------------------------------------------------
package twv_pkg;

    // bar height width, fixed by the stream payload
    localparam int HEIGHT_BITS  = 16;
    // default number of bars a sequence may store
    localparam int MAX_LEN_DEF  = 1024;
    // fewest stored bars for which the backward scan is run
    localparam int MIN_BARS     = 2;

    // result total width and saturation value
    localparam int TOTAL_W      = 26;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 32;

    // sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_TAIL,
        ST_DONE
    } t_state;

    // control from the sequencer to the backward scan datapath
    typedef struct packed {
        logic clear;
        logic step;
    } t_scan_ctl;

endpackage

// ===== hw/rtl/twv_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twv_store
// Single-port-write, single-port-read bar memory with a registered read port.
// Each entry holds the left maximum and the height of one bar.
// ----------------------------------------------------------------------------
module twv_store #(
    parameter int DEPTH = twv_pkg::MAX_LEN_DEF,
    parameter int WIDTH = 2 * twv_pkg::HEIGHT_BITS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    import twv_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/twv_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twv_scan
// Backward pass datapath: running suffix maximum and saturating water sum,
// one bar per step.
// ----------------------------------------------------------------------------
module twv_scan (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  twv_pkg::t_scan_ctl                i_ctl,
    input  logic [twv_pkg::HEIGHT_BITS-1:0]   i_height,
    input  logic [twv_pkg::HEIGHT_BITS-1:0]   i_left_max,
    output logic [twv_pkg::TOTAL_W-1:0]       o_sum
);
    import twv_pkg::*;

    logic [HEIGHT_BITS-1:0] r_suffix, n_suffix;
    logic [TOTAL_W-1:0]     r_sum, n_sum;
    logic [HEIGHT_BITS-1:0] level;
    logic [HEIGHT_BITS-1:0] depth;
    logic [TOTAL_W:0]       sum_ext;

    // water level over this bar and the amount it holds
    always_comb begin
        level   = (i_left_max < r_suffix) ? i_left_max : r_suffix;
        depth   = (level > i_height) ? (level - i_height) : '0;
        sum_ext = {1'b0, r_sum} + (TOTAL_W+1)'(depth);
    end

    // next suffix max and saturated sum
    always_comb begin
        n_suffix = r_suffix;
        n_sum    = r_sum;
        if (i_ctl.clear) begin
            n_suffix = '0;
            n_sum    = '0;
        end else if (i_ctl.step) begin
            n_suffix = (i_height > r_suffix) ? i_height : r_suffix;
            n_sum    = (sum_ext > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_suffix <= '0;
            r_sum    <= '0;
        end else begin
            r_suffix <= n_suffix;
            r_sum    <= n_sum;
        end
    end

    assign o_sum = r_sum;

`ifndef SYNTHESIS
    // a clear leaves an empty accumulator
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> (r_sum == '0) && (r_suffix == '0))
        else $error("scan clear did not empty the accumulator");

    // the sum never shrinks during a pass
    a_sum_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.step && !i_ctl.clear) |=> (r_sum >= $past(r_sum)))
        else $error("water sum decreased during the pass");

    // the suffix max never shrinks during a pass
    a_suffix_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.step && !i_ctl.clear) |=> (r_suffix >= $past(r_suffix)))
        else $error("suffix maximum decreased during the pass");
`endif

endmodule

// ===== hw/rtl/trapped_water_volume_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapped_water_volume_core
// Stores a sequence of bar heights with their left maxima, then scans the
// store backward and returns the total trapped water of the sequence.
// ----------------------------------------------------------------------------
// Load: one bar per cycle, the input is ready in every load cycle.
// Scan: after the bar with tlast, the input stalls while the single memory
//   read port walks the store backward (skipped if n < 2 stored bars); the
//   result is registered in the done state once the output side is free.
// A new sequence is taken only after the result of the last is registered.
// Reset (synchronous, active low) clears the sequencer and the output; the
//   bar memory is not cleared, every entry is written before it is read.
module trapped_water_volume_core #(
    parameter int MAX_LEN = twv_pkg::MAX_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [twv_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,  // [15:0] height
    input  logic                            i_s_axis_tlast,
    // master side
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [twv_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,  // [25:0] water_total
    output logic                            o_m_axis_tuser   // [0] overflow
);
    import twv_pkg::*;

    localparam int AW    = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int MEM_W = 2 * HEIGHT_BITS;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [HEIGHT_BITS-1:0] r_run_max, n_run_max;
    logic                   r_drop, n_drop;
    logic [AW-1:0]          r_ptr, n_ptr;
    logic                   r_rd_valid;
    logic                   r_out_valid, n_out_valid;
    logic [TOTAL_W-1:0]     r_out_total, n_out_total;
    logic                   r_out_ovf, n_out_ovf;

    logic                   in_fire;
    logic                   has_room;
    logic [CNT_W-1:0]       cnt_after;
    logic                   out_free;
    logic [HEIGHT_BITS-1:0] in_height;
    logic                   mem_we;
    logic                   mem_re;
    logic [MEM_W-1:0]       mem_rdata;
    t_scan_ctl              scan_ctl;
    logic [TOTAL_W-1:0]     scan_sum;

    // input transaction and store bookkeeping
    assign in_height = i_s_axis_tdata[HEIGHT_BITS-1:0];
    assign in_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign has_room  = (r_cnt < CNT_W'(MAX_LEN));
    assign cnt_after = has_room ? (r_cnt + 1'b1) : r_cnt;
    assign out_free  = !r_out_valid || i_m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (in_fire && i_s_axis_tlast) begin
                    n_state = (cnt_after < CNT_W'(MIN_BARS)) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_ptr == '0) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = (r_state == ST_LOAD);
        mem_re          = (r_state == ST_SCAN);
        mem_we          = in_fire && has_room;
        scan_ctl.clear  = in_fire && i_s_axis_tlast;
        scan_ctl.step   = r_rd_valid;
    end

    // sequence registers and output register
    always_comb begin
        n_cnt       = r_cnt;
        n_run_max   = r_run_max;
        n_drop      = r_drop;
        n_ptr       = r_ptr;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_total = r_out_total;
        n_out_ovf   = r_out_ovf;
        if (in_fire) begin
            if (has_room) begin
                n_cnt     = cnt_after;
                n_run_max = (in_height > r_run_max) ? in_height : r_run_max;
            end else begin
                n_drop = 1'b1;
            end
            if (i_s_axis_tlast) begin
                n_ptr = AW'(cnt_after - 1'b1);
            end
        end
        if (r_state == ST_SCAN) begin
            n_ptr = r_ptr - 1'b1;
        end
        if ((r_state == ST_DONE) && out_free) begin
            n_out_valid = 1'b1;
            n_out_total = scan_sum;
            n_out_ovf   = r_drop;
            n_cnt       = '0;
            n_run_max   = '0;
            n_drop      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_cnt       <= '0;
            r_run_max   <= '0;
            r_drop      <= 1'b0;
            r_ptr       <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_run_max   <= n_run_max;
            r_drop      <= n_drop;
            r_ptr       <= n_ptr;
            r_rd_valid  <= mem_re;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_total <= n_out_total;
        r_out_ovf   <= n_out_ovf;
    end

    // bar memory: {left max, height}
    twv_store #(
        .DEPTH (MAX_LEN),
        .WIDTH (MEM_W),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata ({r_run_max, in_height}),
        .i_re    (mem_re),
        .i_raddr (r_ptr),
        .o_rdata (mem_rdata)
    );

    // backward scan datapath
    twv_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_height   (mem_rdata[HEIGHT_BITS-1:0]),
        .i_left_max (mem_rdata[MEM_W-1:HEIGHT_BITS]),
        .o_sum      (scan_sum)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W-TOTAL_W){1'b0}}, r_out_total};
    assign o_m_axis_tuser  = r_out_ovf;

`ifndef SYNTHESIS
    // the fill count never passes the store depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_LEN))
        else $error("bar count beyond store depth");

    // a new result only comes out of the done state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid && !i_m_axis_tready))
            |-> $past(r_state == ST_DONE))
        else $error("result loaded outside the done state");

    // read data is consumed in the cycle after each scan read
    a_read_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |=> r_rd_valid && (r_state == ST_SCAN || r_state == ST_TAIL))
        else $error("scan read not followed by its data step");

    // no bar is taken while the store is being scanned
    a_no_load_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_TAIL) |-> !mem_we)
        else $error("store written during the backward pass");
`endif

endmodule
